// ===== sv/ndss_pkg.sv =====
// ndss_pkg: status codes and sequencer state type for the naive dss front extension
// no dependencies
package ndss_pkg;
   localparam logic [2:0] ST_REJECT  = 3'd0;
   localparam logic [2:0] ST_INTER   = 3'd1;
   localparam logic [2:0] ST_UPPER   = 3'd2;
   localparam logic [2:0] ST_LOWER   = 3'd3;
   localparam logic [2:0] ST_ABOVE   = 3'd4;
   localparam logic [2:0] ST_BELOW   = 3'd5;
   localparam logic [2:0] ST_RESTART = 3'd6;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_REM   = 8'b0000_0010,
      S_CLASS = 8'b0000_0100,
      S_GCD   = 8'b0000_1000,
      S_DIVA  = 8'b0001_0000,
      S_DIVB  = 8'b0010_0000,
      S_MU    = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;
endpackage

// ===== sv/ndss_if.sv =====
// ndss_if: valid/ready channel with a generic payload
// depends on nothing
interface ndss_if #(parameter int W = 1) (input logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/naive_dss_front_extension.sv =====
// Naive digital straight segment recognizer, front extension. One beat in gives one beat out.
// A restart beat seeds the segment from two points; an extend beat classifies one point
// against mu <= a*x-b*y < mu+omega and widens the slope on a weakly exterior point. Items are
// taken one at a time. An interior, leaning or rejected point goes through its remainder and
// class steps before its result is registered. A restart runs k euclid steps on the two slope
// components (k bounded by about 1.5*CB), then the two slope divisions and the mu product; each
// euclid step and each slope division runs on the shared one-bit-per-cycle divider. A widening
// point first goes through its remainder and class steps and then through the restart steps.
// The input opens again the cycle after a result is registered; a result waiting in the
// output register does not hold off the next beat, only the next result.
module naive_dss_front_extension #(
   parameter int COORD_BITS = 16
) (
   input logic clock,
   input logic reset,
   ndss_if.sink   req,
   ndss_if.source rsp
);
   import ndss_pkg::*;
   localparam int CB = COORD_BITS;
   localparam int SW = CB + 1;
   localparam int MW = 2 * CB + 3;
   localparam int PW = 2 * CB;

   // request payload: func, px, py, second_x, second_y (func 1 bit, coordinates 16 bit fields)
   logic        req_func;
   logic [15:0] req_px, req_py, req_sx, req_sy;
   assign {req_func, req_px, req_py, req_sx, req_sy} = req.data;

   state_type state_ff, state_in;
   logic signed [SW-1:0] a_ff, a_in, b_ff, b_in;
   logic signed [MW-1:0] mu_ff, mu_in;
   logic [SW-1:0] om_ff, om_in;
   logic [PW-1:0] uf_ff, uf_in, ul_ff, ul_in, lf_ff, lf_in, ll_ff, ll_in;
   // working registers
   logic          func_ff, func_in;
   logic [PW-1:0] p_ff, p_in, mp_ff, mp_in;
   logic signed [MW-1:0] r_ff, r_in;
   logic [SW-1:0] u_ff, u_in, v_ff, v_in, g_ff, g_in;
   logic signed [SW-1:0] dy_ff, dy_in, dx_ff, dx_in;
   logic          rem_ph_ff, rem_ph_in;
   logic signed [MW-1:0] prod_ff, prod_in;
   logic [2:0]    stat_ff, stat_in;
   logic          ov_ff, ov_in;
   logic [2:0]    ost_ff;
   logic signed [SW-1:0] oa_ff, ob_ff;
   logic signed [MW-1:0] omu_ff;
   logic [15:0]   oom_ff;

   // shared divider
   logic          dv_start, dv_done;
   logic [SW-1:0] dv_num, dv_den, dv_q, dv_r;
   ndss_divu #(.W(SW)) u_div (.clock, .reset, .start(dv_start), .num(dv_num),
      .den(dv_den), .done(dv_done), .quo(dv_q), .rem(dv_r));

   function automatic logic [PW-1:0] pk(input logic [15:0] x, input logic [15:0] y);
      logic [CB-1:0] xc, yc;
      xc = CB'(x); yc = CB'(y);
      return {yc, xc};
   endfunction
   function automatic logic [SW-1:0] mg(input logic signed [SW-1:0] v);
      return v[SW-1] ? SW'(-v) : SW'(v);
   endfunction

   // shared multiplier operand select: a*x in phase 0, b*y in phase 1
   logic signed [SW:0]       m_op1;
   logic signed [CB+1:0]     m_op2;
   logic signed [2*SW+1:0]   m_full;
   logic signed [MW-1:0]     m_prod;
   always_comb begin
      m_op1 = rem_ph_ff ? (SW+1)'(b_ff) : (SW+1)'(a_ff);
      m_op2 = rem_ph_ff ? $signed({2'b00, mp_ff[PW-1:CB]}) : $signed({2'b00, mp_ff[CB-1:0]});
      m_full = m_op1 * m_op2;
      m_prod = MW'(m_full);
   end

   logic signed [MW-1:0] top, top_m1, mu_m1;
   logic signed [SW-1:0] qa_s;
   logic [SW-1:0] ma, mb;
   logic [PW-1:0] sp;
   always_comb begin
      state_in = state_ff;
      a_in = a_ff; b_in = b_ff; mu_in = mu_ff; om_in = om_ff;
      uf_in = uf_ff; ul_in = ul_ff; lf_in = lf_ff; ll_in = ll_ff;
      func_in = func_ff; p_in = p_ff; mp_in = mp_ff;
      r_in = r_ff; u_in = u_ff; v_in = v_ff; g_in = g_ff; dy_in = dy_ff; dx_in = dx_ff;
      rem_ph_in = rem_ph_ff; prod_in = prod_ff; stat_in = stat_ff; ov_in = ov_ff;
      dv_start = 1'b0; dv_num = u_ff; dv_den = v_ff;
      top = mu_ff + MW'($signed({1'b0, om_ff}));
      top_m1 = top - MW'(1);
      mu_m1 = mu_ff - MW'(1);
      qa_s = '0; ma = '0; mb = '0; sp = '0;
      if (rsp.ready) ov_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               func_in = req_func;
               p_in = pk(req_px, req_py);
               mp_in = pk(req_px, req_py);
               rem_ph_in = 1'b0;
               if (!req_func) begin
                  uf_in = pk(req_px, req_py); lf_in = pk(req_px, req_py);
                  ul_in = pk(req_sx, req_sy); ll_in = pk(req_sx, req_sy);
                  stat_in = ST_RESTART;
                  state_in = S_GCD;
                  // seed euclid with the magnitudes of the direction
                  dy_in = SW'($signed({1'b0, CB'(req_sy)})) - SW'($signed({1'b0, CB'(req_py)}));
                  dx_in = SW'($signed({1'b0, CB'(req_sx)})) - SW'($signed({1'b0, CB'(req_px)}));
                  u_in = mg(dy_in);
                  v_in = mg(dx_in);
                  g_in = '0;
               end else begin
                  state_in = S_REM;
               end
            end
         end
         S_REM: begin
            // two multiply beats through one multiplier
            if (!rem_ph_ff) begin
               prod_in = m_prod; rem_ph_in = 1'b1;
            end else begin
               r_in = prod_ff - m_prod; rem_ph_in = 1'b0;
               state_in = func_ff ? S_CLASS : S_OUT;
               if (!func_ff) mu_in = prod_ff - m_prod;
               if (func_ff && g_ff == '1) begin
                  mu_in = prod_ff - m_prod; state_in = S_OUT;
               end
            end
         end
         S_CLASS: begin
            state_in = S_OUT;
            if (r_ff > mu_ff && r_ff < top_m1) stat_in = ST_INTER;
            else if (r_ff == mu_ff) begin
               ul_in = p_ff; stat_in = ST_UPPER;
            end else if (r_ff == top_m1) begin
               ll_in = p_ff; stat_in = ST_LOWER;
            end else if (r_ff == mu_m1) begin
               ul_in = p_ff; lf_in = ll_ff; stat_in = ST_ABOVE;
               sp = uf_ff; mp_in = uf_ff; state_in = S_GCD;
            end else if (r_ff == top) begin
               ll_in = p_ff; uf_in = ul_ff; stat_in = ST_BELOW;
               sp = lf_ff; mp_in = ul_ff; state_in = S_GCD;
            end else stat_in = ST_REJECT;
            if (state_in == S_GCD) begin
               dy_in = SW'($signed({1'b0, p_ff[PW-1:CB]})) - SW'($signed({1'b0, sp[PW-1:CB]}));
               dx_in = SW'($signed({1'b0, p_ff[CB-1:0]})) - SW'($signed({1'b0, sp[CB-1:0]}));
               u_in = mg(dy_in); v_in = mg(dx_in); g_in = '0;
            end
         end
         S_GCD: begin
            // g_ff==0 marks idle divider; otherwise waiting
            if (v_ff == '0) begin
               g_in = (u_ff == '0) ? SW'(1) : u_ff;
               state_in = S_DIVA;
               dv_start = 1'b1; dv_num = mg(dy_ff);
               dv_den = (u_ff == '0) ? SW'(1) : u_ff;
            end else if (g_ff == '0) begin
               dv_start = 1'b1; dv_num = u_ff; dv_den = v_ff; g_in = SW'(1);
            end else if (dv_done) begin
               u_in = v_ff; v_in = dv_r; g_in = '0;
            end
         end
         S_DIVA: begin
            if (dv_done) begin
               qa_s = dy_ff[SW-1] ? SW'(-$signed(dv_q)) : $signed(dv_q);
               a_in = qa_s;
               dv_start = 1'b1; dv_num = mg(dx_ff); dv_den = g_ff;
               state_in = S_DIVB;
            end
         end
         S_DIVB: begin
            if (dv_done) begin
               b_in = dx_ff[SW-1] ? SW'(-$signed(dv_q)) : $signed(dv_q);
               ma = mg(a_ff); mb = dv_q;
               om_in = (ma > mb) ? ma : mb;
               state_in = S_MU;
            end
         end
         S_MU: begin
            rem_ph_in = 1'b0; g_in = '1; state_in = S_REM;
         end
         S_OUT: begin
            // load when the output register is empty or being emptied this cycle
            if (!ov_ff || rsp.ready) begin
               ov_in = 1'b1; g_in = '0; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ov_ff <= 1'b0;
         a_ff <= '0; b_ff <= SW'(1); mu_ff <= '0; om_ff <= SW'(1);
         uf_ff <= '0; ul_ff <= '0; lf_ff <= '0; ll_ff <= '0;
         g_ff <= '0; rem_ph_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ov_ff <= ov_in;
         a_ff <= a_in; b_ff <= b_in; mu_ff <= mu_in; om_ff <= om_in;
         uf_ff <= uf_in; ul_ff <= ul_in; lf_ff <= lf_in; ll_ff <= ll_in;
         g_ff <= g_in; rem_ph_ff <= rem_ph_in;
      end
      func_ff <= func_in; p_ff <= p_in; mp_ff <= mp_in;
      r_ff <= r_in; u_ff <= u_in; v_ff <= v_in; dy_ff <= dy_in; dx_ff <= dx_in;
      prod_ff <= prod_in; stat_ff <= stat_in;
      // output register loads on the final beat
      if (state_ff == S_OUT && (!ov_ff || rsp.ready)) begin
         ost_ff <= stat_ff;
         oa_ff <= a_ff; ob_ff <= b_ff;
         omu_ff <= mu_ff;
         oom_ff <= 16'(om_ff);
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = ov_ff;
   assign rsp.data = {ost_ff, 17'($signed(oa_ff)), 17'($signed(ob_ff)),
                      35'($signed(omu_ff)), oom_ff};
endmodule

// ===== sv/ndss_divu.sv =====
// ndss_divu: shared radix-2 restoring divider, one quotient bit per cycle
// depends on nothing
module ndss_divu #(parameter int W = 17) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] quo,
   output logic [W-1:0] rem
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0]  q_ff, q_in, r_ff, r_in;
   logic [W-1:0]  d_ff, d_in;
   logic [CW-1:0] c_ff, c_in;
   logic          busy_ff, busy_in;
   logic [W:0]    trial;
   logic [W-1:0]  q_step, r_step;

   // one restoring step on the current partial remainder
   always_comb begin
      trial = {r_ff, q_ff[W-1]};
      if (trial >= {1'b0, d_ff}) begin
         r_step = W'(trial - {1'b0, d_ff});
         q_step = {q_ff[W-2:0], 1'b1};
      end else begin
         r_step = trial[W-1:0];
         q_step = {q_ff[W-2:0], 1'b0};
      end
   end

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; c_in = c_ff; busy_in = busy_ff;
      if (start) begin
         q_in = num; r_in = '0; d_in = den; c_in = CW'(W); busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = q_step;
         r_in = r_step;
         c_in = c_ff - 1'b1;
         if (c_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; c_ff <= '0;
      end else begin
         busy_ff <= busy_in; c_ff <= c_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   // final step results stay visible even when a new division starts
   assign done = busy_ff && (c_ff == CW'(1));
   assign quo = q_step;
   assign rem = r_step;
endmodule

// ===== sv/ndss_checker.sv =====
// ndss_checker: port level checks for naive_dss_front_extension
// depends on ndss_if via the bound top level ports
module ndss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [87:0] rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while busy");
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data[87:85] != 3'd7)
      else $error("bad status");
endmodule

bind naive_dss_front_extension ndss_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));
